@@ rtl/rtmap_pkg.sv @@
// package: shared types, status codes and controller/datapath command bundles
`timescale 1ns / 1ps

package rtmap_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // what the node memory write port stores
    typedef enum logic [1:0] {
        W_ZERO_AT_NODE = 2'd0,
        W_ZERO_AT_FREE = 2'd1,
        W_LINK_NODE    = 2'd2,
        W_LINK_LEAF    = 2'd3
    } t_wsel;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ROOT,
        S_READ,
        S_CHK,
        S_LINK,
        S_NEW,
        S_LLINK,
        S_LEAF_WR,
        S_LEAF_RD,
        S_LEAF_CHK,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    root_set;
        logic    nram_re;
        logic    nram_we;
        t_wsel   wsel;
        logic    node_from_slot;
        logic    node_from_free;
        logic    level_inc;
        logic    node_alloc;
        logic    leaf_from_slot;
        logic    leaf_alloc;
        logic    leaf_re;
        logic    leaf_we;
        logic    res_load;
        logic    res_success;
        t_status res_status;
        logic    res_coords;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mode;
        logic root_present;
        logic slot_valid;
        logic last_level;
        logic node_full;
        logic leaf_full;
        logic id_match;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/rtmap_ram.sv @@
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps

module rtmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rtmap_ctrl.sv @@
// controller: state machine sequencing the trie walk, allocation and result
`timescale 1ns / 1ps

module rtmap_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rtmap_pkg::t_sts i_sts,
    output rtmap_pkg::t_cmd o_cmd
);

    import rtmap_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_sts.mode == MODE_LOOKUP) begin
                    if (!i_sts.root_present) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (!i_sts.root_present) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_ROOT: begin
                // clear the root row on first insert
                o_cmd.nram_we  = 1'b1;
                o_cmd.wsel     = W_ZERO_AT_NODE;
                o_cmd.root_set = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.nram_re = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.mode == MODE_LOOKUP) begin
                    if (!i_sts.slot_valid) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.node_from_slot = 1'b1;
                        if (i_sts.last_level) begin
                            n_state = S_LEAF_RD;
                        end else begin
                            o_cmd.level_inc = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                end else if (!i_sts.last_level) begin
                    // inner level of an insert
                    if (i_sts.slot_valid) begin
                        o_cmd.node_from_slot = 1'b1;
                        o_cmd.level_inc      = 1'b1;
                        n_state              = S_READ;
                    end else if (i_sts.node_full) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    // leaf level of an insert
                    if (i_sts.slot_valid) begin
                        o_cmd.leaf_from_slot = 1'b1;
                        o_cmd.res_load       = 1'b1;
                        o_cmd.res_success    = 1'b1;
                        o_cmd.res_status     = ST_DUPLICATE;
                        n_state              = S_LEAF_WR;
                    end else if (i_sts.leaf_full) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_success = 1'b1;
                        o_cmd.res_status  = ST_OK;
                        n_state           = S_LLINK;
                    end
                end
            end
            S_LINK: begin
                // point the parent slot at the next free node
                o_cmd.nram_we = 1'b1;
                o_cmd.wsel    = W_LINK_NODE;
                n_state       = S_NEW;
            end
            S_NEW: begin
                // clear the new node and step into it
                o_cmd.nram_we        = 1'b1;
                o_cmd.wsel           = W_ZERO_AT_FREE;
                o_cmd.node_from_free = 1'b1;
                o_cmd.node_alloc     = 1'b1;
                o_cmd.level_inc      = 1'b1;
                n_state              = S_READ;
            end
            S_LLINK: begin
                o_cmd.nram_we    = 1'b1;
                o_cmd.wsel       = W_LINK_LEAF;
                o_cmd.leaf_alloc = 1'b1;
                n_state          = S_LEAF_WR;
            end
            S_LEAF_WR: begin
                o_cmd.leaf_we = 1'b1;
                n_state       = S_DONE;
            end
            S_LEAF_RD: begin
                o_cmd.leaf_re = 1'b1;
                n_state       = S_LEAF_CHK;
            end
            S_LEAF_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_sts.id_match) begin
                    o_cmd.res_success = 1'b1;
                    o_cmd.res_status  = ST_OK;
                    o_cmd.res_coords  = 1'b1;
                end else begin
                    o_cmd.res_status = ST_MISMATCH;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rtmap_dp.sv @@
// datapath: request registers, node and leaf memories, pool counters, result
`timescale 1ns / 1ps

module rtmap_dp #(
    parameter int NODE_COUNT  = 4096,
    parameter int LEAF_COUNT  = 4096,
    parameter int STRIDE_BITS = 4,
    parameter int KEY_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtmap_pkg::t_cmd     i_cmd,
    output rtmap_pkg::t_sts     o_sts,
    input  logic                i_mode,
    input  logic [63:0]         i_node_id,
    input  logic signed [30:0]  i_latitude,
    input  logic signed [31:0]  i_longitude,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_success,
    output logic [2:0]          o_status,
    output logic signed [30:0]  o_latitude_out,
    output logic signed [31:0]  o_longitude_out
);

    import rtmap_pkg::*;

    localparam int FANOUT    = 1 << STRIDE_BITS;
    localparam int LEVELS    = KEY_BITS / STRIDE_BITS;
    localparam int MAX_COUNT = (NODE_COUNT > LEAF_COUNT) ? NODE_COUNT : LEAF_COUNT;
    localparam int IDX_W     = $clog2(MAX_COUNT);
    localparam int SLOT_W    = IDX_W + 1;
    localparam int ROW_W     = FANOUT * SLOT_W;
    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int LEAF_AW   = $clog2(LEAF_COUNT);
    localparam int NFN_W     = $clog2(NODE_COUNT + 1);
    localparam int NFL_W     = $clog2(LEAF_COUNT + 1);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int REC_W     = 64 + 31 + 32;

    // request
    logic                    r_mode;
    logic [63:0]             r_id;
    logic [KEY_BITS-1:0]     r_key;
    logic signed [30:0]      r_lat;
    logic signed [31:0]      r_lon;
    // walk
    logic [IDX_W-1:0]        r_node;
    logic [LVL_W-1:0]        r_level;
    logic [LEAF_AW-1:0]      r_leaf;
    // pools
    logic                    r_root;
    logic [NFN_W-1:0]        r_nfn;
    logic [NFL_W-1:0]        r_nfl;
    // pending result and output word
    logic                    r_res_success;
    t_status                 r_res_status;
    logic signed [30:0]      r_res_lat;
    logic signed [31:0]      r_res_lon;
    logic                    r_out_valid;
    logic                    r_out_success;
    logic [2:0]              r_out_status;
    logic signed [30:0]      r_out_lat;
    logic signed [31:0]      r_out_lon;

    logic [ROW_W-1:0]        w_row;
    logic [ROW_W-1:0]        w_link_row;
    logic [ROW_W-1:0]        w_nram_wdata;
    logic [NODE_AW-1:0]      w_nram_waddr;
    logic [STRIDE_BITS-1:0]  w_digit;
    logic [SLOT_W-1:0]       w_slot;
    logic [IDX_W-1:0]        w_link_idx;
    logic [REC_W-1:0]        w_rec;

    assign w_digit = r_key[STRIDE_BITS-1:0];
    assign w_slot  = w_row[int'(w_digit) * SLOT_W +: SLOT_W];

    // parent row with the current slot linked
    always_comb begin
        w_link_idx = (i_cmd.wsel == W_LINK_LEAF) ? IDX_W'(r_nfl) : IDX_W'(r_nfn);
        w_link_row = w_row;
        w_link_row[int'(w_digit) * SLOT_W +: SLOT_W] = {1'b1, w_link_idx};
    end

    // node memory write address and data
    always_comb begin
        case (i_cmd.wsel)
            W_ZERO_AT_NODE: begin
                w_nram_waddr = r_node[NODE_AW-1:0];
                w_nram_wdata = '0;
            end
            W_ZERO_AT_FREE: begin
                w_nram_waddr = r_nfn[NODE_AW-1:0];
                w_nram_wdata = '0;
            end
            W_LINK_NODE, W_LINK_LEAF: begin
                w_nram_waddr = r_node[NODE_AW-1:0];
                w_nram_wdata = w_link_row;
            end
            default: begin
                w_nram_waddr = r_node[NODE_AW-1:0];
                w_nram_wdata = '0;
            end
        endcase
    end

    // one row per node holding all child slots
    rtmap_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.nram_we),
        .i_waddr (w_nram_waddr),
        .i_wdata (w_nram_wdata),
        .i_re    (i_cmd.nram_re),
        .i_raddr (r_node[NODE_AW-1:0]),
        .o_rdata (w_row)
    );

    // leaf records {id, latitude, longitude}
    rtmap_ram #(
        .WIDTH (REC_W),
        .DEPTH (LEAF_COUNT)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.leaf_we),
        .i_waddr (r_leaf),
        .i_wdata ({r_id, r_lat, r_lon}),
        .i_re    (i_cmd.leaf_re),
        .i_raddr (r_node[LEAF_AW-1:0]),
        .o_rdata (w_rec)
    );

    // request capture and walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_id    <= i_node_id;
            r_key   <= i_node_id[KEY_BITS-1:0];
            r_lat   <= i_latitude;
            r_lon   <= i_longitude;
            r_node  <= '0;
            r_level <= '0;
        end else begin
            if (i_cmd.node_from_slot) begin
                r_node <= w_slot[IDX_W-1:0];
            end else if (i_cmd.node_from_free) begin
                r_node <= IDX_W'(r_nfn);
            end
            if (i_cmd.level_inc) begin
                r_level <= r_level + 1'b1;
                r_key   <= r_key >> STRIDE_BITS;
            end
        end
        if (i_cmd.leaf_from_slot) begin
            r_leaf <= w_slot[LEAF_AW-1:0];
        end else if (i_cmd.leaf_alloc) begin
            r_leaf <= r_nfl[LEAF_AW-1:0];
        end
    end

    // root flag and pool counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= 1'b0;
            r_nfn  <= NFN_W'(1);
            r_nfl  <= '0;
        end else begin
            if (i_cmd.root_set) begin
                r_root <= 1'b1;
            end
            if (i_cmd.node_alloc) begin
                r_nfn <= r_nfn + 1'b1;
            end
            if (i_cmd.leaf_alloc) begin
                r_nfl <= r_nfl + 1'b1;
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_success <= i_cmd.res_success;
            r_res_status  <= i_cmd.res_status;
            r_res_lat     <= i_cmd.res_coords ? $signed(w_rec[62:32]) : '0;
            r_res_lon     <= i_cmd.res_coords ? $signed(w_rec[31:0]) : '0;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_success <= r_res_success;
            r_out_status  <= r_res_status;
            r_out_lat     <= r_res_lat;
            r_out_lon     <= r_res_lon;
        end
    end

    // status to the controller
    assign o_sts.mode         = r_mode;
    assign o_sts.root_present = r_root;
    assign o_sts.slot_valid   = w_slot[SLOT_W-1];
    assign o_sts.last_level   = (r_level == LVL_W'(LEVELS - 1));
    assign o_sts.node_full    = (r_nfn >= NFN_W'(NODE_COUNT));
    assign o_sts.leaf_full    = (r_nfl >= NFL_W'(LEAF_COUNT));
    assign o_sts.id_match     = (w_rec[REC_W-1:63] == r_id);
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_success       = r_out_success;
    assign o_status        = r_out_status;
    assign o_latitude_out  = r_out_lat;
    assign o_longitude_out = r_out_lon;

endmodule

@@ rtl/radix_trie_id_to_coord_map.sv @@
// top level: multibit trie store mapping node ids to coordinate pairs
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | mode, node_id, latitude, longitude
//  out     | output    | o_out_valid / i_out_stall  | success, status, lat/lon out
//
// One request at a time. A walk reads the node row and checks the slot at each trie level,
// and each newly allocated inner node adds a parent link and a row clear; with the default
// parameters the trie has eight levels. A miss or a full pool ends the walk early.
// Reset clears the root flag, the pool counters and the output valid flag; memories hold no reset.
// The next request is taken while a finished word waits on a stalled output.
`timescale 1ns / 1ps

module radix_trie_id_to_coord_map #(
    parameter int NODE_COUNT  = 4096,
    parameter int LEAF_COUNT  = 4096,
    parameter int STRIDE_BITS = 4,
    parameter int KEY_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [63:0]        i_node_id,
    input  logic signed [30:0] i_latitude,
    input  logic signed [31:0] i_longitude,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_success,
    output logic [2:0]         o_status,
    output logic signed [30:0] o_latitude_out,
    output logic signed [31:0] o_longitude_out
);

    import rtmap_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    rtmap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage and result path
    rtmap_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .LEAF_COUNT  (LEAF_COUNT),
        .STRIDE_BITS (STRIDE_BITS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_node_id       (i_node_id),
        .i_latitude      (i_latitude),
        .i_longitude     (i_longitude),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_success       (o_success),
        .o_status        (o_status),
        .o_latitude_out  (o_latitude_out),
        .o_longitude_out (o_longitude_out)
    );

endmodule
